// ----- rtl/core/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg
// Shared widths, types and helpers for the 2D segment intersection pipeline.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CP_W    = PROD_W + 1;
    localparam int MAG_W   = CP_W - 1;
    localparam int NUM_W   = MAG_W + DIFF_W;
    localparam int Q_W     = DIFF_W;
    localparam int TOL_W   = 32;
    localparam int PIPE_LAT = 6 + Q_W;

    localparam logic IDX_OVERLAP = 1'b0;
    localparam logic IDX_TOL     = 1'b1;

    typedef enum logic [2:0] {
        REL_CROSS    = 3'd0,
        REL_OVERLAP  = 3'd1,
        REL_DISJOINT = 3'd2,
        REL_PARALLEL = 3'd3,
        REL_APART    = 3'd4
    } rel_t;

    typedef struct packed {
        logic signed [CP_W-1:0]    rxs;
        logic signed [CP_W-1:0]    dxr;
        logic signed [CP_W-1:0]    dxs;
        logic signed [CP_W-1:0]    dot_a;
        logic signed [CP_W-1:0]    dot_b;
        logic signed [CP_W-1:0]    dot_rr;
        logic signed [CP_W-1:0]    dot_ds;
        logic signed [CP_W-1:0]    dot_ss;
        logic                      r_zero;
        logic                      s_zero;
        logic                      d_zero;
        logic signed [DIFF_W-1:0]  rx;
        logic signed [DIFF_W-1:0]  ry;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } sums_t;

    typedef struct packed {
        rel_t                      rel;
        logic                      meets;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } class_t;

    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        logic signed [PROD_W-1:0] ea;
        logic signed [PROD_W-1:0] eb;
        ea = PROD_W'(a);
        eb = PROD_W'(b);
        return ea * eb;
    endfunction

    function automatic logic [MAG_W-1:0] cmag(input logic signed [CP_W-1:0] v);
        logic signed [CP_W-1:0] n;
        n = -v;
        return v[CP_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/core/sid_front.sv -----
// ----------------------------------------------------------------------------
// sid_front
// Three stages: coordinate differences, products, cross and dot sums.
// ----------------------------------------------------------------------------
module sid_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [sid_pkg::COORD_W-1:0] p_start_x,
    input  logic signed [sid_pkg::COORD_W-1:0] p_start_y,
    input  logic signed [sid_pkg::COORD_W-1:0] p_end_x,
    input  logic signed [sid_pkg::COORD_W-1:0] p_end_y,
    input  logic signed [sid_pkg::COORD_W-1:0] q_start_x,
    input  logic signed [sid_pkg::COORD_W-1:0] q_start_y,
    input  logic signed [sid_pkg::COORD_W-1:0] q_end_x,
    input  logic signed [sid_pkg::COORD_W-1:0] q_end_y,
    output logic                               out_valid,
    output sid_pkg::sums_t                     sums
);
    import sid_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] rx_reg, ry_reg, sx_reg, sy_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [COORD_W-1:0] px1_reg, py1_reg, px2_reg, py2_reg;
    logic signed [PROD_W-1:0] rxsy_reg, rysx_reg, dxry_reg, dyrx_reg;
    logic signed [PROD_W-1:0] dxsy_reg, dysx_reg, dxrx_reg, dyry_reg;
    logic signed [PROD_W-1:0] exrx_reg, eyry_reg, rxrx_reg, ryry_reg;
    logic signed [PROD_W-1:0] dxsx_reg, dysy_reg, sxsx_reg, sysy_reg;
    logic signed [DIFF_W-1:0] rx2_reg, ry2_reg;
    logic r_zero2_reg, s_zero2_reg, d_zero2_reg;
    sums_t sums_reg;

    function automatic logic signed [DIFF_W-1:0] dif(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic signed [CP_W-1:0] ext(input logic signed [PROD_W-1:0] a);
        return CP_W'(a);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= dif(p_end_x, p_start_x);
        ry_reg  <= dif(p_end_y, p_start_y);
        sx_reg  <= dif(q_end_x, q_start_x);
        sy_reg  <= dif(q_end_y, q_start_y);
        dx_reg  <= dif(q_start_x, p_start_x);
        dy_reg  <= dif(q_start_y, p_start_y);
        ex_reg  <= dif(q_end_x, p_start_x);
        ey_reg  <= dif(q_end_y, p_start_y);
        px1_reg <= p_start_x;
        py1_reg <= p_start_y;

        rxsy_reg <= smul(rx_reg, sy_reg);
        rysx_reg <= smul(ry_reg, sx_reg);
        dxry_reg <= smul(dx_reg, ry_reg);
        dyrx_reg <= smul(dy_reg, rx_reg);
        dxsy_reg <= smul(dx_reg, sy_reg);
        dysx_reg <= smul(dy_reg, sx_reg);
        dxrx_reg <= smul(dx_reg, rx_reg);
        dyry_reg <= smul(dy_reg, ry_reg);
        exrx_reg <= smul(ex_reg, rx_reg);
        eyry_reg <= smul(ey_reg, ry_reg);
        rxrx_reg <= smul(rx_reg, rx_reg);
        ryry_reg <= smul(ry_reg, ry_reg);
        dxsx_reg <= smul(dx_reg, sx_reg);
        dysy_reg <= smul(dy_reg, sy_reg);
        sxsx_reg <= smul(sx_reg, sx_reg);
        sysy_reg <= smul(sy_reg, sy_reg);
        rx2_reg  <= rx_reg;
        ry2_reg  <= ry_reg;
        px2_reg  <= px1_reg;
        py2_reg  <= py1_reg;
        r_zero2_reg <= (rx_reg == '0) && (ry_reg == '0);
        s_zero2_reg <= (sx_reg == '0) && (sy_reg == '0);
        d_zero2_reg <= (dx_reg == '0) && (dy_reg == '0);

        sums_reg.rxs    <= ext(rxsy_reg) - ext(rysx_reg);
        sums_reg.dxr    <= ext(dxry_reg) - ext(dyrx_reg);
        sums_reg.dxs    <= ext(dxsy_reg) - ext(dysx_reg);
        sums_reg.dot_a  <= ext(dxrx_reg) + ext(dyry_reg);
        sums_reg.dot_b  <= ext(exrx_reg) + ext(eyry_reg);
        sums_reg.dot_rr <= ext(rxrx_reg) + ext(ryry_reg);
        sums_reg.dot_ds <= ext(dxsx_reg) + ext(dysy_reg);
        sums_reg.dot_ss <= ext(sxsx_reg) + ext(sysy_reg);
        sums_reg.r_zero <= r_zero2_reg;
        sums_reg.s_zero <= s_zero2_reg;
        sums_reg.d_zero <= d_zero2_reg;
        sums_reg.rx     <= rx2_reg;
        sums_reg.ry     <= ry2_reg;
        sums_reg.px     <= px2_reg;
        sums_reg.py     <= py2_reg;
    end

    assign out_valid = v3_reg;
    assign sums      = sums_reg;

endmodule

// ----- rtl/core/sid_classify.sv -----
// ----------------------------------------------------------------------------
// sid_classify
// Two stages: magnitudes and ordering, then relation and divide numerators.
// ----------------------------------------------------------------------------
module sid_classify
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            overlap_counts,
    input  logic [sid_pkg::TOL_W-1:0]       zero_tolerance,
    input  logic                            in_valid,
    input  sid_pkg::sums_t                  sums,
    output logic                            out_valid,
    output sid_pkg::class_t                 cls,
    output logic [sid_pkg::NUM_W-1:0]       num_x,
    output logic [sid_pkg::NUM_W-1:0]       num_y,
    output logic [sid_pkg::MAG_W-1:0]       den
);
    import sid_pkg::*;

    logic a_valid_reg, b_valid_reg;
    logic [MAG_W-1:0] m_rxs_reg, m_dxr_reg, m_dxs_reg;
    logic s_rxs_reg, s_dxr_reg, s_dxs_reg;
    logic z_dxr_reg, z_dxs_reg;
    logic signed [CP_W-1:0] lo_reg, hi_reg, rr_reg, ds_reg, ss_reg;
    logic r_zero_reg, s_zero_reg, d_zero_reg;
    logic [DIFF_W-1:0] m_rx_reg, m_ry_reg;
    logic s_rx_reg, s_ry_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    class_t cls_reg;
    logic [NUM_W-1:0] num_x_reg, num_y_reg;
    logic [MAG_W-1:0] den_reg;

    logic ab_le;
    logic signed [DIFF_W-1:0] nrx, nry;
    logic signed [CP_W:0] ds_ss;
    logic [MAG_W:0] tol_ext;
    logic nz_rxs, nz_dxr, ov, unit_t, unit_u;
    class_t cls_next;

    assign ab_le = sums.dot_a <= sums.dot_b;
    assign nrx   = -sums.rx;
    assign nry   = -sums.ry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_rxs_reg  <= cmag(sums.rxs);
        m_dxr_reg  <= cmag(sums.dxr);
        m_dxs_reg  <= cmag(sums.dxs);
        s_rxs_reg  <= sums.rxs[CP_W-1];
        s_dxr_reg  <= sums.dxr[CP_W-1];
        s_dxs_reg  <= sums.dxs[CP_W-1];
        z_dxr_reg  <= sums.dxr == '0;
        z_dxs_reg  <= sums.dxs == '0;
        lo_reg     <= ab_le ? sums.dot_a : sums.dot_b;
        hi_reg     <= ab_le ? sums.dot_b : sums.dot_a;
        rr_reg     <= sums.dot_rr;
        ds_reg     <= sums.dot_ds;
        ss_reg     <= sums.dot_ss;
        r_zero_reg <= sums.r_zero;
        s_zero_reg <= sums.s_zero;
        d_zero_reg <= sums.d_zero;
        m_rx_reg   <= sums.rx[DIFF_W-1] ? nrx : sums.rx;
        m_ry_reg   <= sums.ry[DIFF_W-1] ? nry : sums.ry;
        s_rx_reg   <= sums.rx[DIFF_W-1];
        s_ry_reg   <= sums.ry[DIFF_W-1];
        px_reg     <= sums.px;
        py_reg     <= sums.py;
    end

    assign tol_ext = (MAG_W + 1)'(zero_tolerance);
    assign ds_ss   = (CP_W + 1)'(ds_reg) + (CP_W + 1)'(ss_reg);

    always_comb
    begin
        nz_rxs = (MAG_W + 1)'(m_rxs_reg) <= tol_ext;
        nz_dxr = (MAG_W + 1)'(m_dxr_reg) <= tol_ext;
        unit_t = z_dxs_reg || ((s_dxs_reg == s_rxs_reg) && (m_dxs_reg <= m_rxs_reg));
        unit_u = z_dxr_reg || ((s_dxr_reg == s_rxs_reg) && (m_dxr_reg <= m_rxs_reg));
        priority if (r_zero_reg && s_zero_reg)
            ov = d_zero_reg;
        else if (r_zero_reg)
            ov = (ds_reg[CP_W-1] || (ds_reg == '0)) && !ds_ss[CP_W];
        else
            ov = (lo_reg <= rr_reg) && !hi_reg[CP_W-1];

        cls_next.meets = 1'b0;
        priority if (nz_rxs && nz_dxr)
        begin
            cls_next.rel   = ov ? REL_OVERLAP : REL_DISJOINT;
            cls_next.meets = ov && overlap_counts;
        end
        else if (nz_rxs)
            cls_next.rel = REL_PARALLEL;
        else if (unit_t && unit_u)
        begin
            cls_next.rel   = REL_CROSS;
            cls_next.meets = 1'b1;
        end
        else
            cls_next.rel = REL_APART;
        cls_next.neg_x = s_dxs_reg != (s_rxs_reg != s_rx_reg);
        cls_next.neg_y = s_dxs_reg != (s_rxs_reg != s_ry_reg);
        cls_next.px    = px_reg;
        cls_next.py    = py_reg;
    end

    always_ff @(posedge clk)
    begin
        cls_reg   <= cls_next;
        num_x_reg <= NUM_W'(m_dxs_reg) * NUM_W'(m_rx_reg);
        num_y_reg <= NUM_W'(m_dxs_reg) * NUM_W'(m_ry_reg);
        den_reg   <= m_rxs_reg;
    end

    assign out_valid = b_valid_reg;
    assign cls       = cls_reg;
    assign num_x     = num_x_reg;
    assign num_y     = num_y_reg;
    assign den       = den_reg;

endmodule

// ----- rtl/core/sid_div.sv -----
// ----------------------------------------------------------------------------
// sid_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sid_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [sid_pkg::NUM_W-1:0]   num,
    input  logic [sid_pkg::MAG_W-1:0]   den,
    output logic                        out_valid,
    output logic [sid_pkg::Q_W-1:0]     quo
);
    import sid_pkg::*;

    genvar j;
    generate
        for (j = 0; j < Q_W; j++)
        begin : g_stage
            logic             vld_reg;
            logic [NUM_W-1:0] rem_reg;
            logic [MAG_W-1:0] den_reg;
            logic [Q_W-1:0]   quo_reg;
            logic             vld_in;
            logic [NUM_W-1:0] rem_in;
            logic [MAG_W-1:0] den_in;
            logic [Q_W-1:0]   quo_in;
            logic [NUM_W-1:0] shd;
            logic             take;

            if (j == 0)
            begin : g_first
                assign vld_in = in_valid;
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign vld_in = g_stage[j-1].vld_reg;
                assign rem_in = g_stage[j-1].rem_reg;
                assign den_in = g_stage[j-1].den_reg;
                assign quo_in = g_stage[j-1].quo_reg;
            end

            assign shd  = NUM_W'(den_in) << (Q_W - 1 - j);
            assign take = rem_in >= shd;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg <= 1'b0;
                else
                    vld_reg <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg <= take ? rem_in - shd : rem_in;
                den_reg <= den_in;
                quo_reg <= quo_in | (take ? (Q_W'(1) << (Q_W - 1 - j)) : '0);
            end
        end
    endgenerate

    assign out_valid = g_stage[Q_W-1].vld_reg;
    assign quo       = g_stage[Q_W-1].quo_reg;

endmodule

// ----- rtl/core/segment_intersection_2d.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Classifies two 2D Q8.8 segments and returns the crossing point.
//
//   channel   handshake            payload
//   request   start / busy         p_start_*, p_end_*, q_start_*, q_end_*
//   result    done (one cycle)     meets, relation, point_x, point_y
//   config    wr_en                wr_index, wr_data
//
// One request per cycle; busy is always low. The pipeline holds 3 front stages,
// 2 classify stages, one divider stage per quotient bit (17) and one output
// stage. Reset clears all valid bits and the configuration registers. The
// receiver cannot stall.
// ----------------------------------------------------------------------------
module segment_intersection_2d
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sid_pkg::COORD_W-1:0] p_start_x,
    input  logic signed [sid_pkg::COORD_W-1:0] p_start_y,
    input  logic signed [sid_pkg::COORD_W-1:0] p_end_x,
    input  logic signed [sid_pkg::COORD_W-1:0] p_end_y,
    input  logic signed [sid_pkg::COORD_W-1:0] q_start_x,
    input  logic signed [sid_pkg::COORD_W-1:0] q_start_y,
    input  logic signed [sid_pkg::COORD_W-1:0] q_end_x,
    input  logic signed [sid_pkg::COORD_W-1:0] q_end_y,
    input  logic                               wr_en,
    input  logic                               wr_index,
    input  logic [sid_pkg::TOL_W-1:0]          wr_data,
    output logic                               done,
    output logic                               meets,
    output logic [2:0]                         relation,
    output logic signed [sid_pkg::COORD_W-1:0] point_x,
    output logic signed [sid_pkg::COORD_W-1:0] point_y
);
    import sid_pkg::*;

    logic             overlap_reg;
    logic [TOL_W-1:0] tol_reg;

    logic             f_valid, c_valid, dx_valid, dy_valid;
    sums_t            sums;
    class_t           cls;
    logic [NUM_W-1:0] num_x, num_y;
    logic [MAG_W-1:0] den;
    logic [Q_W-1:0]   quo_x, quo_y;

    class_t           meta_reg [Q_W];

    logic             done_reg, meets_reg;
    logic [2:0]       rel_reg;
    logic signed [COORD_W-1:0] px_out_reg, py_out_reg;
    logic [COORD_W-1:0] off_x, off_y;
    class_t           m_out;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_reg <= 1'b0;
            tol_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                IDX_OVERLAP: overlap_reg <= wr_data[0];
                IDX_TOL:     tol_reg     <= wr_data;
                default:     ;
            endcase
        end
    end

    sid_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .p_start_x (p_start_x),
        .p_start_y (p_start_y),
        .p_end_x   (p_end_x),
        .p_end_y   (p_end_y),
        .q_start_x (q_start_x),
        .q_start_y (q_start_y),
        .q_end_x   (q_end_x),
        .q_end_y   (q_end_y),
        .out_valid (f_valid),
        .sums      (sums)
    );

    sid_classify u_classify
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .overlap_counts (overlap_reg),
        .zero_tolerance (tol_reg),
        .in_valid       (f_valid),
        .sums           (sums),
        .out_valid      (c_valid),
        .cls            (cls),
        .num_x          (num_x),
        .num_y          (num_y),
        .den            (den)
    );

    sid_div u_div_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .num       (num_x),
        .den       (den),
        .out_valid (dx_valid),
        .quo       (quo_x)
    );

    sid_div u_div_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .num       (num_y),
        .den       (den),
        .out_valid (dy_valid),
        .quo       (quo_y)
    );

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= cls;
        for (int i = 1; i < Q_W; i++)
        begin
            meta_reg[i] <= meta_reg[i-1];
        end
    end

    assign m_out = meta_reg[Q_W-1];
    assign off_x = m_out.neg_x ? -quo_x[COORD_W-1:0] : quo_x[COORD_W-1:0];
    assign off_y = m_out.neg_y ? -quo_y[COORD_W-1:0] : quo_y[COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dx_valid;
    end

    always_ff @(posedge clk)
    begin
        meets_reg <= m_out.meets;
        rel_reg   <= m_out.rel;
        if (m_out.rel == REL_CROSS)
        begin
            px_out_reg <= m_out.px + off_x;
            py_out_reg <= m_out.py + off_y;
        end
        else
        begin
            px_out_reg <= '0;
            py_out_reg <= '0;
        end
    end

    assign done     = done_reg;
    assign meets    = meets_reg;
    assign relation = rel_reg;
    assign point_x  = px_out_reg;
    assign point_y  = py_out_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("result strobe missing after request");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_valid == dy_valid)
        else $error("divider lanes out of step");

    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && relation != REL_CROSS) |-> (point_x == '0 && point_y == '0))
        else $error("point nonzero without a crossing");

    a_meets_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && meets) |-> (relation == REL_CROSS || relation == REL_OVERLAP))
        else $error("meets set for a non-meeting relation");

endmodule

// ----- sim/tb_segment_intersection_2d.sv -----
// ----------------------------------------------------------------------------
// tb_segment_intersection_2d
// Streams segment pairs through the intersection pipeline and checks every
// result against an exact integer predictor. Tolerance and overlap mode are
// changed between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_segment_intersection_2d;

    timeunit 1ns;
    timeprecision 1ps;

    import sid_pkg::*;

    localparam int DRAIN       = PIPE_LAT + 10;
    localparam int WATCHDOG    = 2000;

    typedef logic signed [15:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic   meets;
        rel_t   rel;
        coord_t x;
        coord_t y;
    } verdict_t;

    typedef struct packed {
        coord_t px, py, p2x, p2y, qx, qy, q2x, q2y;
    } pair_t;

    class verdict_board;
        verdict_t pending[$];
        int errors;
        int checked;
        logic overlap_mode;
        logic [31:0] tol;

        function bit near_zero(wide_t v);
            wide_t a;
            a = (v < 0) ? -v : v;
            return a <= wide_t'({96'd0, tol});
        endfunction

        function bit in_unit(wide_t num, wide_t den);
            if (num == 0) return 1;
            if ((num < 0) != (den < 0)) return 0;
            return ((num < 0) ? -num : num) <= ((den < 0) ? -den : den);
        endfunction

        function coord_t shift(wide_t num, wide_t den, wide_t dir);
            wide_t an, ad, ar, o;
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            ar = (dir < 0) ? -dir : dir;
            o = (an * ar) / ad;
            if ((num < 0) != ((den < 0) != (dir < 0))) o = -o;
            return o[15:0];
        endfunction

        function void note_request(pair_t p);
            wide_t rx, ry, sx, sy, dx, dy, rxs, dxr, dxs, a, b, lo, hi, c;
            verdict_t v;
            bit ov;
            rx = p.p2x - p.px; ry = p.p2y - p.py;
            sx = p.q2x - p.qx; sy = p.q2y - p.qy;
            dx = p.qx - p.px;  dy = p.qy - p.py;
            rxs = rx * sy - ry * sx;
            dxr = dx * ry - dy * rx;
            v = '0;
            v.rel = REL_APART;
            if (near_zero(rxs) && near_zero(dxr)) begin
                if (rx == 0 && ry == 0) begin
                    if (sx == 0 && sy == 0)
                        ov = (dx == 0 && dy == 0);
                    else begin
                        c = -dx * sx - dy * sy;
                        ov = (c >= 0) && (c <= sx * sx + sy * sy);
                    end
                end
                else begin
                    a = dx * rx + dy * ry;
                    b = (wide_t'(p.q2x) - p.px) * rx + (wide_t'(p.q2y) - p.py) * ry;
                    lo = (a <= b) ? a : b;
                    hi = (a <= b) ? b : a;
                    ov = (lo <= rx * rx + ry * ry) && (hi >= 0);
                end
                v.rel = ov ? REL_OVERLAP : REL_DISJOINT;
                v.meets = ov && overlap_mode;
            end
            else if (near_zero(rxs))
                v.rel = REL_PARALLEL;
            else begin
                dxs = dx * sy - dy * sx;
                if (in_unit(dxs, rxs) && in_unit(dxr, rxs)) begin
                    v.rel = REL_CROSS;
                    v.meets = 1'b1;
                    v.x = p.px + shift(dxs, rxs, rx);
                    v.y = p.py + shift(dxs, rxs, ry);
                end
            end
            pending.push_back(v);
        endfunction

        function void check_result(verdict_t got);
            verdict_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.meets !== e.meets) begin
                $error("meets exp %0d got %0d", e.meets, got.meets); errors++;
            end
            if (got.rel !== e.rel) begin
                $error("relation exp %0d got %0d", e.rel, got.rel); errors++;
            end
            if (got.x !== e.x) begin
                $error("point_x exp %0d got %0d", e.x, got.x); errors++;
            end
            if (got.y !== e.y) begin
                $error("point_y exp %0d got %0d", e.y, got.y); errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, wr_en, wr_index, done, meets;
    logic [31:0] wr_data;
    logic [2:0] relation;
    coord_t p_start_x, p_start_y, p_end_x, p_end_y;
    coord_t q_start_x, q_start_y, q_end_x, q_end_y, point_x, point_y;

    verdict_board board;
    int idle_cycles;
    int requests;
    bit quiet;

    segment_intersection_2d i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result({meets, rel_t'(relation), point_x, point_y});
        if (rst_n && ((start && !busy) || done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(int idx, logic [31:0] val);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx[0];
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == IDX_OVERLAP) board.overlap_mode = val[0];
        else board.tol = val;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // request held on start until the accepting edge
    task automatic send(pair_t p);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        {p_start_x, p_start_y, p_end_x, p_end_y,
         q_start_x, q_start_y, q_end_x, q_end_y} = p;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(p);
        requests++;
        @(negedge clk);
    endtask

    task automatic idle_line();
        start = 1'b0;
        @(negedge clk);
    endtask

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 64) - 32);
            default: return coord_t'($urandom_range(0, 4096) - 2048);
        endcase
    endfunction

    function automatic pair_t rnd_pair();
        pair_t p;
        int m, k, j;
        coord_t dx, dy;
        m = $urandom_range(0, 2);
        p = {rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m),
             rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m)};
        k = $urandom_range(0, 9);
        if (k < 3)
        begin
            // collinear: both on one line through p_start
            dx = rnd_coord(1); dy = rnd_coord(1);
            j = $urandom_range(0, 8);
            p.p2x = coord_t'(p.px + dx * j); p.p2y = coord_t'(p.py + dy * j);
            j = $urandom_range(0, 16) - 6;
            p.qx = coord_t'(p.px + dx * j); p.qy = coord_t'(p.py + dy * j);
            j = $urandom_range(0, 16) - 6;
            p.q2x = coord_t'(p.px + dx * j); p.q2y = coord_t'(p.py + dy * j);
        end
        else if (k < 5)
        begin
            // parallel offset
            dx = p.p2x - p.px; dy = p.p2y - p.py;
            p.q2x = p.qx + dx; p.q2y = p.qy + dy;
        end
        else if (k == 5)
        begin
            p.q2x = p.px; p.q2y = p.py;
        end
        return p;
    endfunction

    initial
    begin
        pair_t dp;
        board = new();
        idle_cycles = 0;
        requests = 0;
        quiet = 1'b0;
        start = 1'b0; wr_en = 1'b0; wr_index = 1'b0; wr_data = '0;
        {p_start_x, p_start_y, p_end_x, p_end_y,
         q_start_x, q_start_y, q_end_x, q_end_y} = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(IDX_OVERLAP, 32'd1);
        write_reg(IDX_TOL, 32'd0);
        quiet = 1'b1;
        send({16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd256, 16'sd256, 16'sd0});
        send({16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd256, 16'sd0, 16'sd768, 16'sd0});
        send({16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd512, 16'sd0, 16'sd768, 16'sd0});
        send({16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd1, 16'sd256, 16'sd1});
        send({16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd10, 16'sd256, 16'sd300});
        send({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd10, 16'sd10});
        send({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd20, 16'sd20, 16'sd30, 16'sd30});
        send({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5});
        send({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5, 16'sd6, 16'sd5});
        send({16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd256});
        send({16'sd0, 16'sd0, 16'sd3, 16'sd7, 16'sd0, 16'sd5, 16'sd2, 16'sd0});
        send({-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
              -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
        send({16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
              -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767});
        send({-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
        send({16'sd0, 16'sd0, -16'sd300, 16'sd7, 16'sd5, -16'sd9, -16'sd100, 16'sd40});
        idle_line();
        drain();

        write_reg(IDX_OVERLAP, 32'd0);
        dp = {16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd256, 16'sd0, 16'sd768, 16'sd0};
        send(dp);
        quiet = 1'b0;
        for (int phase = 0; phase < 6; phase++)
        begin
            idle_line();
            drain();
            case (phase)
                0: write_reg(IDX_TOL, 32'hFFFF_FFFF);
                1: write_reg(IDX_TOL, 32'd1000);
                2: begin write_reg(IDX_TOL, 32'd0); write_reg(IDX_OVERLAP, 32'd1); end
                3: write_reg(IDX_TOL, $urandom_range(0, 100000));
                4: write_reg(IDX_OVERLAP, 32'd0);
                default: write_reg(IDX_TOL, 32'd0);
            endcase
            quiet = (phase == 5);
            for (int n = 0; n < 320; n++) send(rnd_pair());
        end
        idle_line();
        drain();

        $display("%0d requests, %0d results checked over several tolerance and overlap settings",
                 requests, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
